FILE: rtl/tick_uart_pwm_watchdog_controller_assert.svh
// Assertion macros shared by the controller RTL.
`ifndef TICK_UART_PWM_WATCHDOG_CONTROLLER_ASSERT_SVH
`define TICK_UART_PWM_WATCHDOG_CONTROLLER_ASSERT_SVH

// Antecedent in this cycle implies the consequent in the same cycle.
`define TUPWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tupwc: same-cycle check failed");

// Antecedent in this cycle implies the consequent in the next cycle.
`define TUPWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tupwc: next-cycle check failed");

`endif

FILE: rtl/tupwc_pkg.sv
`timescale 1ns / 1ps

package tupwc_pkg;

    // Event codes carried by the func field.
    typedef enum logic [1:0] {
        FUNC_BIT_TICK = 2'd0,
        FUNC_BUTTON   = 2'd1,
        FUNC_TEN_MS   = 2'd2,
        FUNC_PWM_STEP = 2'd3
    } t_func;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WDT_LIMIT = 2'd0,
        CFG_WARN_AT   = 2'd1,
        CFG_ACK_BYTE  = 2'd2,
        CFG_WARN_BYTE = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [3:0] FRAME_BITS       = 4'd10;
    localparam logic [6:0] PWM_STEPS        = 7'd100;
    localparam logic [6:0] TICKS_PER_SECOND = 7'd100;
    localparam logic [2:0] LEVEL_LAST       = 3'd5;

    localparam logic [9:0] WDT_LIMIT_RST = 10'd120;
    localparam logic [9:0] WARN_AT_RST   = 10'd20;
    localparam logic [7:0] ACK_BYTE_RST  = 8'h1b;
    localparam logic [7:0] WARN_BYTE_RST = 8'hee;

    // Control from the supervisor to the serial port.
    typedef struct packed {
        logic bit_tick;
        logic rx_line;
        logic load_warn;
    } t_uart_ctl;

    // Status from the serial port.
    typedef struct packed {
        logic       start;
        logic       n_tx_level;
        logic [7:0] n_rx_byte;
        logic [7:0] rx_byte;
    } t_uart_stat;

    // Duty table for the six brightness levels.
    function automatic logic [6:0] duty_of_level(input logic [2:0] level);
        logic [6:0] duty;
        unique case (level)
            3'd0:    duty = 7'd0;
            3'd1:    duty = 7'd10;
            3'd2:    duty = 7'd25;
            3'd3:    duty = 7'd50;
            3'd4:    duty = 7'd75;
            3'd5:    duty = 7'd100;
            default: duty = 7'd0;
        endcase
        return duty;
    endfunction

    // Lowest nonzero brightness level whose duty is not below a duty taken from a received byte.
    function automatic logic [2:0] level_of_duty(input logic [6:0] duty);
        logic [2:0] level;
        priority if (duty <= 7'd10) level = 3'd1;
        else if (duty <= 7'd25)     level = 3'd2;
        else if (duty <= 7'd50)     level = 3'd3;
        else if (duty <= 7'd75)     level = 3'd4;
        else                        level = 3'd5;
        return level;
    endfunction

    // byte * 100 / 255, with the divide done as an exact shift-add reciprocal.
    function automatic logic [6:0] duty_of_byte(input logic [7:0] rx_byte);
        logic [15:0] prod;
        logic [15:0] sum;
        prod = 16'(rx_byte) * 16'd100 + 16'd1;
        sum  = prod + (prod >> 8);
        return sum[14:8];
    endfunction

endpackage

FILE: rtl/tupwc_in_if.sv
`timescale 1ns / 1ps

// Event item channel.
interface tupwc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       rx_line;

    modport source (output valid, output func, output rx_line, input ready);
    modport sink   (input valid, input func, input rx_line, output ready);
endinterface

FILE: rtl/tupwc_out_if.sv
`timescale 1ns / 1ps

// Result item channel.
interface tupwc_out_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic       led;
    logic       wdt_kick;
    logic [2:0] level_index;
    logic [7:0] rx_byte;
    logic       rx_priority;

    modport source (output valid, output tx_line, output led, output wdt_kick,
                    output level_index, output rx_byte, output rx_priority,
                    input ready);
    modport sink   (input valid, input tx_line, input led, input wdt_kick,
                    input level_index, input rx_byte, input rx_priority,
                    output ready);
endinterface

FILE: rtl/tick_uart_pwm_watchdog_controller.sv
// An accepted item moves on from the input register into the result register
// when that register is empty or its result is taken. Throughput: one item
// per cycle while results are taken; the input register and result register
// form a two-stage pipeline, so one more item is taken while a result waits.
// Reset (synchronous, active low) idles the serial port, clears the
// supervisor, dimmer and pipeline, and restores the register defaults.
`timescale 1ns / 1ps

`include "tick_uart_pwm_watchdog_controller_assert.svh"

module tick_uart_pwm_watchdog_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tupwc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tupwc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    tupwc_in_if.sink                              i_in,
    tupwc_out_if.source                           o_out
);

    // Configuration registers.
    logic [9:0] r_wdt_limit;
    logic [9:0] r_warn_at;
    logic [7:0] r_ack_byte;
    logic [7:0] r_warn_byte;

    // Input stage.
    logic             r_in_valid;
    tupwc_pkg::t_func r_func;
    logic             r_rx;

    // Controller state.
    logic       r_prio,     n_prio;
    logic [2:0] r_level,    n_level;
    logic [6:0] r_tens,     n_tens;
    logic [9:0] r_secs,     n_secs;
    logic [6:0] r_step,     n_step;
    logic [6:0] r_duty,     n_duty;
    logic       r_from_rx,  n_from_rx;
    logic       r_led,      n_led;
    logic       kick;

    // Result stage.
    logic       r_out_valid;
    logic       r_o_tx, r_o_led, r_o_kick, r_o_prio;
    logic [2:0] r_o_level;
    logic [7:0] r_o_rx_byte;

    logic                  advance;
    logic                  fire;
    logic [9:0]            threshold;
    logic [9:0]            remaining;
    logic                  sec_due;
    logic [6:0]            duty_sel;
    logic                  from_sel;
    tupwc_pkg::t_uart_ctl  uart_ctl;
    tupwc_pkg::t_uart_stat uart_stat;

    // Pipeline handshake.
    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wdt_limit <= tupwc_pkg::WDT_LIMIT_RST;
            r_warn_at   <= tupwc_pkg::WARN_AT_RST;
            r_ack_byte  <= tupwc_pkg::ACK_BYTE_RST;
            r_warn_byte <= tupwc_pkg::WARN_BYTE_RST;
        end else if (i_cfg_we) begin
            unique case (tupwc_pkg::t_cfg_idx'(i_cfg_idx))
                tupwc_pkg::CFG_WDT_LIMIT: r_wdt_limit <= i_cfg_data;
                tupwc_pkg::CFG_WARN_AT:   r_warn_at   <= i_cfg_data;
                tupwc_pkg::CFG_ACK_BYTE:  r_ack_byte  <= i_cfg_data[7:0];
                tupwc_pkg::CFG_WARN_BYTE: r_warn_byte <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Supervisor arithmetic for the one-second point.
    assign threshold = (r_wdt_limit >= 10'd2) ? r_wdt_limit - 10'd2 : 10'd0;
    assign remaining = (r_secs < threshold) ? threshold - r_secs : 10'd0;
    assign sec_due   = (r_tens >= tupwc_pkg::TICKS_PER_SECOND);

    assign uart_ctl.bit_tick  = fire && (r_func == tupwc_pkg::FUNC_BIT_TICK);
    assign uart_ctl.rx_line   = r_rx;
    assign uart_ctl.load_warn = fire && (r_func == tupwc_pkg::FUNC_TEN_MS) && sec_due
                                && (remaining != 10'd0) && (remaining == r_warn_at);

    tupwc_uart u_uart (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (uart_ctl),
        .i_ack_byte  (r_ack_byte),
        .i_warn_byte (r_warn_byte),
        .o_stat      (uart_stat)
    );

    // Duty chosen at the start of a PWM period.
    always_comb begin
        if (r_step == 7'd0) begin
            from_sel = r_prio;
            duty_sel = r_prio ? tupwc_pkg::duty_of_byte(uart_stat.rx_byte)
                              : tupwc_pkg::duty_of_level(r_level);
        end else begin
            from_sel = r_from_rx;
            duty_sel = r_duty;
        end
    end

    // Next controller state for the item in the input stage.
    always_comb begin
        n_prio    = r_prio;
        n_level   = r_level;
        n_tens    = r_tens;
        n_secs    = r_secs;
        n_step    = r_step;
        n_duty    = r_duty;
        n_from_rx = r_from_rx;
        n_led     = r_led;
        kick      = 1'b0;
        if (fire) begin
            unique case (r_func)
                tupwc_pkg::FUNC_BIT_TICK: begin
                    if (uart_stat.start) begin
                        n_prio = 1'b1;
                        n_tens = '0;
                        n_secs = '0;
                        kick   = 1'b1;
                    end
                end
                tupwc_pkg::FUNC_BUTTON: begin
                    n_level = (r_level == tupwc_pkg::LEVEL_LAST) ? 3'd0 : r_level + 3'd1;
                    n_prio  = 1'b0;
                    n_tens  = '0;
                    n_secs  = '0;
                    kick    = 1'b1;
                end
                tupwc_pkg::FUNC_TEN_MS: begin
                    if (sec_due) begin
                        if (remaining != 10'd0) begin
                            n_secs = r_secs + 10'd1;
                            n_tens = 7'd1;
                            kick   = 1'b1;
                        end
                    end else begin
                        n_tens = r_tens + 7'd1;
                    end
                end
                tupwc_pkg::FUNC_PWM_STEP: begin
                    n_duty    = duty_sel;
                    n_from_rx = from_sel;
                    n_led     = (r_step < duty_sel);
                    if (r_step == tupwc_pkg::PWM_STEPS - 7'd1) begin
                        n_step = '0;
                        if (from_sel) begin
                            n_level = tupwc_pkg::level_of_duty(duty_sel);
                        end
                    end else begin
                        n_step = r_step + 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Input stage, controller state and result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prio      <= 1'b0;
            r_level     <= '0;
            r_tens      <= '0;
            r_secs      <= '0;
            r_step      <= '0;
            r_duty      <= '0;
            r_from_rx   <= 1'b0;
            r_led       <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_prio    <= n_prio;
            r_level   <= n_level;
            r_tens    <= n_tens;
            r_secs    <= n_secs;
            r_step    <= n_step;
            r_duty    <= n_duty;
            r_from_rx <= n_from_rx;
            r_led     <= n_led;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func <= tupwc_pkg::t_func'(i_in.func);
            r_rx   <= i_in.rx_line;
        end
        if (fire) begin
            r_o_tx      <= uart_stat.n_tx_level;
            r_o_led     <= n_led;
            r_o_kick    <= kick;
            r_o_level   <= n_level;
            r_o_rx_byte <= uart_stat.n_rx_byte;
            r_o_prio    <= n_prio;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.tx_line     = r_o_tx;
    assign o_out.led         = r_o_led;
    assign o_out.wdt_kick    = r_o_kick;
    assign o_out.level_index = r_o_level;
    assign o_out.rx_byte     = r_o_rx_byte;
    assign o_out.rx_priority = r_o_prio;

    // A button item always kicks and drops receive priority.
    `TUPWC_ASSERT_NEXT(a_button_kicks, i_clk, i_rst_n,
        fire && (r_func == tupwc_pkg::FUNC_BUTTON),
        o_out.valid && o_out.wdt_kick && !o_out.rx_priority)

    // The tick counter never runs past one second.
    `TUPWC_ASSERT_NOW(a_tens_bound, i_clk, i_rst_n, 1'b1, r_tens <= tupwc_pkg::TICKS_PER_SECOND)

    // The brightness level stays inside the six-entry table.
    `TUPWC_ASSERT_NOW(a_level_bound, i_clk, i_rst_n, 1'b1, r_level <= tupwc_pkg::LEVEL_LAST)

    // A stalled result is not overwritten by a new item.
    `TUPWC_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, r_out_valid && !o_out.ready, !fire)

endmodule

FILE: rtl/tupwc_uart.sv
`timescale 1ns / 1ps

// 8N1 serial port stepped by bit ticks. Receive has precedence over transmit.
module tupwc_uart (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tupwc_pkg::t_uart_ctl  i_ctl,
    input  logic [7:0]            i_ack_byte,
    input  logic [7:0]            i_warn_byte,
    output tupwc_pkg::t_uart_stat o_stat
);

    logic [3:0] r_rx_cnt,   n_rx_cnt;
    logic [7:0] r_rx_data,  n_rx_data;
    logic [9:0] r_tx_shift, n_tx_shift;
    logic [3:0] r_tx_cnt,   n_tx_cnt;
    logic       r_tx_level, n_tx_level;
    logic       start;

    // Next state for one item.
    always_comb begin
        start      = i_ctl.bit_tick && !i_ctl.rx_line && (r_rx_cnt == tupwc_pkg::FRAME_BITS);
        n_rx_cnt   = r_rx_cnt;
        n_rx_data  = r_rx_data;
        n_tx_shift = r_tx_shift;
        n_tx_cnt   = r_tx_cnt;
        n_tx_level = r_tx_level;

        // A start bit opens a receive frame and queues the ack frame.
        if (start) begin
            n_rx_data  = '0;
            n_rx_cnt   = '0;
            n_tx_shift = {1'b1, i_ack_byte, 1'b0};
            n_tx_cnt   = '0;
        end
        if (i_ctl.load_warn) begin
            n_tx_shift = {1'b1, i_warn_byte, 1'b0};
            n_tx_cnt   = '0;
        end

        // Sample one receive bit, or else send one transmit bit.
        if (i_ctl.bit_tick) begin
            if (n_rx_cnt < tupwc_pkg::FRAME_BITS) begin
                for (int i = 0; i < 8; i++) begin
                    if (n_rx_cnt == 4'(i + 1)) begin
                        n_rx_data[i] = i_ctl.rx_line;
                    end
                end
                n_rx_cnt = n_rx_cnt + 4'd1;
            end else if (r_tx_cnt < tupwc_pkg::FRAME_BITS) begin
                for (int i = 0; i < 10; i++) begin
                    if (r_tx_cnt == 4'(i)) begin
                        n_tx_level = r_tx_shift[i];
                    end
                end
                n_tx_cnt = r_tx_cnt + 4'd1;
            end
        end
    end

    // Serial port state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_cnt   <= tupwc_pkg::FRAME_BITS;
            r_rx_data  <= '0;
            r_tx_shift <= '0;
            r_tx_cnt   <= tupwc_pkg::FRAME_BITS;
            r_tx_level <= 1'b1;
        end else begin
            r_rx_cnt   <= n_rx_cnt;
            r_rx_data  <= n_rx_data;
            r_tx_shift <= n_tx_shift;
            r_tx_cnt   <= n_tx_cnt;
            r_tx_level <= n_tx_level;
        end
    end

    assign o_stat.start      = start;
    assign o_stat.n_tx_level = n_tx_level;
    assign o_stat.n_rx_byte  = n_rx_data;
    assign o_stat.rx_byte    = r_rx_data;

endmodule

FILE: tb/tupwc_checker.sv
`timescale 1ns / 1ps

// Watches the event and status channels, predicts every status item from
// the events and register writes it sees, and counts disagreements.
module tupwc_checker
    import tupwc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tupwc_in_if                   i_ev,
    tupwc_out_if                  i_st,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    // One status item as the block reports it.
    typedef struct packed {
        logic       tx_line;
        logic       led;
        logic       wdt_kick;
        logic [2:0] level_index;
        logic [7:0] rx_byte;
        logic       rx_priority;
    } t_status;

    // Register copies.
    logic [9:0] limit_s;
    logic [9:0] warn_at;
    logic [7:0] ack_val;
    logic [7:0] warn_val;

    // Controller state.
    logic [9:0] rx_frame;
    logic [3:0] rx_bits;
    logic [9:0] tx_frame;
    logic [3:0] tx_bits;
    logic       tx_lvl;
    logic       prio;
    logic [2:0] level;
    logic [6:0] ticks_10ms;
    logic [9:0] secs_kicked;
    logic [6:0] pwm_pos;
    logic [6:0] pwm_duty;
    logic       duty_from_rx;
    logic       led_lvl;

    t_status    pending_status[$];
    t_status    want;
    t_status    got;
    int         bad_count = 0;

    assign o_mismatches = bad_count;

    // Applies one event to the controller state and returns the status it shows.
    task automatic step_controller(input t_func ev, input logic rx, output t_status res);
        logic       kick;
        logic [9:0] thr;
        logic [9:0] rem;
        kick = 1'b0;
        case (ev)
            FUNC_BIT_TICK: begin
                // A low line on an idle receiver opens a frame and answers it.
                if (!rx && rx_bits == FRAME_BITS) begin
                    rx_frame    = '0;
                    rx_bits     = '0;
                    prio        = 1'b1;
                    tx_frame    = {1'b1, ack_val, 1'b0};
                    tx_bits     = '0;
                    ticks_10ms  = '0;
                    secs_kicked = '0;
                    kick        = 1'b1;
                end
                // Receiving wins over shifting out.
                if (rx_bits < FRAME_BITS) begin
                    rx_frame = rx_frame | (10'(rx) << rx_bits);
                    rx_bits  = rx_bits + 4'd1;
                end else if (tx_bits < FRAME_BITS) begin
                    tx_lvl  = tx_frame[tx_bits];
                    tx_bits = tx_bits + 4'd1;
                end
            end
            FUNC_BUTTON: begin
                level       = (level == LEVEL_LAST) ? 3'd0 : level + 3'd1;
                prio        = 1'b0;
                ticks_10ms  = '0;
                secs_kicked = '0;
                kick        = 1'b1;
            end
            FUNC_TEN_MS: begin
                // Once a second has passed, kick while time remains.
                if (ticks_10ms >= TICKS_PER_SECOND) begin
                    thr = (limit_s >= 10'd2) ? limit_s - 10'd2 : 10'd0;
                    rem = (secs_kicked < thr) ? thr - secs_kicked : 10'd0;
                    if (rem != 10'd0) begin
                        if (rem == warn_at) begin
                            tx_frame = {1'b1, warn_val, 1'b0};
                            tx_bits  = '0;
                        end
                        secs_kicked = secs_kicked + 10'd1;
                        ticks_10ms  = 7'd1;
                        kick        = 1'b1;
                    end
                end else begin
                    ticks_10ms = ticks_10ms + 7'd1;
                end
            end
            default: begin
                // The duty is latched at the start of each period.
                if (pwm_pos == 7'd0) begin
                    if (prio) begin
                        pwm_duty     = 7'((32'(rx_frame[8:1]) * 100) / 255);
                        duty_from_rx = 1'b1;
                    end else begin
                        case (level)
                            3'd1:    pwm_duty = 7'd10;
                            3'd2:    pwm_duty = 7'd25;
                            3'd3:    pwm_duty = 7'd50;
                            3'd4:    pwm_duty = 7'd75;
                            3'd5:    pwm_duty = 7'd100;
                            default: pwm_duty = 7'd0;
                        endcase
                        duty_from_rx = 1'b0;
                    end
                end
                led_lvl = (pwm_pos < pwm_duty);
                pwm_pos = pwm_pos + 7'd1;
                // At the end of a period a received duty picks the lowest nonzero level whose duty is not below it.
                if (pwm_pos >= PWM_STEPS) begin
                    pwm_pos = '0;
                    if (duty_from_rx) begin
                        if (pwm_duty <= 7'd10)      level = 3'd1;
                        else if (pwm_duty <= 7'd25) level = 3'd2;
                        else if (pwm_duty <= 7'd50) level = 3'd3;
                        else if (pwm_duty <= 7'd75) level = 3'd4;
                        else                        level = 3'd5;
                    end
                end
            end
        endcase
        res = {tx_lvl, led_lvl, kick, level, rx_frame[8:1], prio};
    endtask

    // Register snooping, result checking and prediction, in that order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_s      = WDT_LIMIT_RST;
            warn_at      = WARN_AT_RST;
            ack_val      = ACK_BYTE_RST;
            warn_val     = WARN_BYTE_RST;
            rx_frame     = '0;
            rx_bits      = FRAME_BITS;
            tx_frame     = '0;
            tx_bits      = FRAME_BITS;
            tx_lvl       = 1'b1;
            prio         = 1'b0;
            level        = '0;
            ticks_10ms   = '0;
            secs_kicked  = '0;
            pwm_pos      = '0;
            pwm_duty     = '0;
            duty_from_rx = 1'b0;
            led_lvl      = 1'b0;
            pending_status.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WDT_LIMIT: limit_s  = i_cfg_data[9:0];
                    CFG_WARN_AT:   warn_at  = i_cfg_data[9:0];
                    CFG_ACK_BYTE:  ack_val  = i_cfg_data[7:0];
                    CFG_WARN_BYTE: warn_val = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (i_st.valid && i_st.ready) begin
                got = {i_st.tx_line, i_st.led, i_st.wdt_kick, i_st.level_index,
                       i_st.rx_byte, i_st.rx_priority};
                if (pending_status.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("status item with none pending: %h", got);
                end else begin
                    want = pending_status.pop_front();
                    if (got !== want) begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"status mismatch (expected/actual): tx %b/%b led %b/%b",
                                      " kick %b/%b level %0d/%0d rx_byte %h/%h prio %b/%b"},
                                     want.tx_line, got.tx_line, want.led, got.led,
                                     want.wdt_kick, got.wdt_kick,
                                     want.level_index, got.level_index,
                                     want.rx_byte, got.rx_byte,
                                     want.rx_priority, got.rx_priority);
                    end
                end
            end

            if (i_ev.valid && i_ev.ready) begin
                step_controller(t_func'(i_ev.func), i_ev.rx_line, want);
                pending_status.push_back(want);
            end

            o_outstanding <= pending_status.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Drives events and register settings into the controller and reports the verdict.
module tb_top;
    import tupwc_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 120;

    // Watchdog limit and warning point for each phase, extremes included.
    localparam int unsigned PHASE_LIMIT [PHASES] = '{3, 5, 0, 1, 4, 1023, 6, 2, 1000, 3};
    localparam int unsigned PHASE_WARN  [PHASES] = '{1, 2, 0, 1023, 1, 20, 3, 0, 1000, 2};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles = 0;
    int                    send_calm = 0;

    tupwc_in_if  ev_ch();
    tupwc_out_if st_ch();

    tick_uart_pwm_watchdog_controller uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (ev_ch),
        .o_out      (st_ch)
    );

    tupwc_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_ev          (ev_ch),
        .i_st          (st_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Offers one event after a random gap and holds it until it is taken.
    task automatic send_item(input t_func ev, input logic rx);
        int gap;
        int pick;
        gap = 0;
        if (send_calm > 0) begin
            send_calm--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2)       send_calm = $urandom_range(50, 200);
            else if (pick < 65) gap = 0;
            else if (pick < 95) gap = $urandom_range(1, 3);
            else                gap = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev_ch.valid   <= 1'b1;
        ev_ch.func    <= ev;
        ev_ch.rx_line <= rx;
        do @(posedge i_clk); while (!ev_ch.ready);
    endtask

    // Stops sending and waits until every status item has come back.
    task automatic drain_status();
        ev_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Random bursts: serial frames, supervisor runs, PWM runs, buttons and noise.
    task automatic run_phase(input int budget);
        int sent;
        int kind;
        int len;
        int i;
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                // A frame with random content, then idle ticks to shift out the answer.
                send_item(FUNC_BIT_TICK, 1'b0);
                for (i = 0; i < 9; i++) send_item(FUNC_BIT_TICK, 1'($urandom_range(0, 1)));
                len = $urandom_range(0, 12);
                for (i = 0; i < len; i++) send_item(FUNC_BIT_TICK, 1'b1);
                sent += 10 + len;
            end else if (kind < 55) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(150, 260)
                                                  : $urandom_range(20, 130);
                for (i = 0; i < len; i++) send_item(FUNC_TEN_MS, 1'($urandom_range(0, 1)));
                sent += len;
            end else if (kind < 85) begin
                len = $urandom_range(10, 110);
                for (i = 0; i < len; i++) send_item(FUNC_PWM_STEP, 1'($urandom_range(0, 1)));
                sent += len;
            end else if (kind < 90) begin
                len = $urandom_range(1, 2);
                for (i = 0; i < len; i++) send_item(FUNC_BUTTON, 1'($urandom_range(0, 1)));
                sent += len;
            end else begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                    send_item(t_func'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                sent += len;
            end
        end
    endtask

    // Status-side backpressure: mostly short stalls, a few long ones, calm stretches.
    initial begin : ready_gen
        int calm;
        int stall;
        int pick;
        calm  = 0;
        stall = 0;
        st_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm > 0) begin
                calm--;
                st_ch.ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                st_ch.ready <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3)       calm = $urandom_range(100, 300);
                else if (pick < 5)  stall = $urandom_range(15, 40);
                else if (pick < 30) stall = $urandom_range(1, 3);
                st_ch.ready <= (stall == 0);
            end
        end
    end

    // End the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((ev_ch.valid && ev_ch.ready) || (st_ch.valid && st_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int p;
        int i;
        ev_ch.valid   <= 1'b0;
        ev_ch.func    <= FUNC_BIT_TICK;
        ev_ch.rx_line <= 1'b1;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_WDT_LIMIT;
        cfg_data      <= '0;
        i_rst_n       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first PWM period, a full lap of levels, an idle supervisor
        // tick, an idle line, a frame with all-ones data and a low stop bit,
        // then the answer starts shifting out.
        send_item(FUNC_PWM_STEP, 1'b1);
        for (i = 0; i < 6; i++) send_item(FUNC_BUTTON, 1'(i));
        send_item(FUNC_TEN_MS, 1'b0);
        send_item(FUNC_BIT_TICK, 1'b1);
        send_item(FUNC_BIT_TICK, 1'b0);
        for (i = 0; i < 8; i++) send_item(FUNC_BIT_TICK, 1'b1);
        send_item(FUNC_BIT_TICK, 1'b0);
        for (i = 0; i < 3; i++) send_item(FUNC_BIT_TICK, 1'b1);
        drain_status();

        // Random phases, each under its own register setting.
        for (p = 0; p < PHASES; p++) begin
            write_reg(CFG_WDT_LIMIT, 10'(PHASE_LIMIT[p]));
            write_reg(CFG_WARN_AT, 10'(PHASE_WARN[p]));
            write_reg(CFG_ACK_BYTE, (p == 0) ? 10'h000 :
                                    (p == 1) ? 10'h3ff : 10'($urandom_range(0, 255)));
            write_reg(CFG_WARN_BYTE, (p == 0) ? 10'h0ff :
                                     (p == 1) ? 10'h300 : 10'($urandom_range(0, 255)));
            cfg_we <= 1'b0;
            run_phase(PHASE_LEN);
            drain_status();
        end

        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: tick_uart_pwm_watchdog_controller.f
+incdir+rtl
rtl/tupwc_pkg.sv
rtl/tupwc_in_if.sv
rtl/tupwc_out_if.sv
rtl/tupwc_uart.sv
rtl/tick_uart_pwm_watchdog_controller.sv
tb/tupwc_checker.sv
tb/tb_top.sv
